// File: hw/rtl/qos_frame_budget_tx_scheduler_core_defines.svh
// assertion helpers for the scheduler core
`ifndef QOS_FRAME_BUDGET_TX_SCHEDULER_CORE_DEFINES_SVH
`define QOS_FRAME_BUDGET_TX_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QFB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define QFB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/qfb_pkg.sv
package qfb_pkg;

    // field widths
    localparam int QOS_W  = 8;
    localparam int SIZE_W = 9;
    localparam int TAG_W  = 8;
    localparam int TIME_W = 32;
    localparam int FSZ_W  = 20;
    localparam int UPB_W  = 16;
    localparam int QIDX_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;

    // fixed limits of the scheduler
    localparam int MAX_PAYLOAD  = 256;
    localparam int HEADER_BYTES = 16;

    // default queue depths
    localparam int HIGH_DEPTH_DEF   = 4;
    localparam int MIDDLE_DEPTH_DEF = 10;
    localparam int LOW_DEPTH_DEF    = 16;

    // cost = us_per_byte * (header + payload)
    localparam int COST_SUM_W = $clog2(HEADER_BYTES + (2 ** SIZE_W));
    localparam int COST_W     = UPB_W + COST_SUM_W;

    // reset values of the registers
    localparam logic [FSZ_W-1:0] FRAME_SIZE_RST = FSZ_W'(9500);
    localparam logic [UPB_W-1:0] US_PER_BYTE_RST = UPB_W'(86);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_US_PER_BYTE = 1'b1;

    // queue codes
    localparam logic [QIDX_W-1:0] Q_HIGH = 2'd0;
    localparam logic [QIDX_W-1:0] Q_MID  = 2'd1;
    localparam logic [QIDX_W-1:0] Q_LOW  = 2'd2;

    // qos classes
    localparam logic [QOS_W-1:0] QOS_MID_MIN = 8'h02;
    localparam logic [QOS_W-1:0] QOS_LOW_VAL = 8'hFF;
    localparam logic [QOS_W-1:0] QOS_RESTART = 8'h00;

    // item kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_REQ = 1'b1;

    // one stored packet descriptor
    typedef struct packed {
        logic [QOS_W-1:0]  qos;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } desc_t;

    // queue control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } qctl_t;

    // queue status back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } qsts_t;

    // budget verdicts for the middle and low heads
    typedef struct packed {
        logic mid;
        logic low;
    } fit_t;

    // result item, accepted in the lowest bit
    typedef struct packed {
        logic [QOS_W-1:0]  grant_qos;
        logic [SIZE_W-1:0] grant_payload_size;
        logic [TAG_W-1:0]  grant_tag;
        logic              granted;
        logic [QIDX_W-1:0] queue_index;
        logic              accepted;
    } result_t;

endpackage

// File: hw/rtl/qos_frame_budget_tx_scheduler_core.sv
// Transmit scheduler with high, middle and low descriptor queues.
// Input stream: tuser is the kind (0 enqueue a descriptor, 1 request a
// grant); tdata carries now_us, qos, payload_size and tag.
// Output stream: one result transaction per input transaction, carrying
// acceptance or the granted descriptor.
// Config port: cfg_we with cfg_index 0 writes frame_size_us, 1 writes
// us_per_byte; write only while no transaction is in flight.
// Sequencing: an accepted input passes the EVAL then DONE state; its result
// is loaded into the output register as DONE is left, when the next input
// is taken, so one item is evaluated at a time. The steps are the registered
// queue head read followed by the registered budget multiply and compare.
// Reset: queues empty, frame_size_us 9500, us_per_byte 86, frame end 9500;
// no memory clearing pass is needed.
// Receiver stall: the result waits in the output register; one more input
// transaction is accepted and evaluated, then the input side waits until
// the pending result is taken.
`include "qos_frame_budget_tx_scheduler_core_defines.svh"

module qos_frame_budget_tx_scheduler_core
    import qfb_pkg::*;
#(
    parameter int HIGH_DEPTH   = HIGH_DEPTH_DEF,
    parameter int MIDDLE_DEPTH = MIDDLE_DEPTH_DEF,
    parameter int LOW_DEPTH    = LOW_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // now_us[31:0], qos[39:32], payload_size[48:40], tag[56:49], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // accepted[0], queue_index[2:1], granted[3], grant_tag[11:4],
    // grant_payload_size[20:12], grant_qos[28:21], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_DONE} state_t;

    state_t state_reg, state_next;

    logic [FSZ_W-1:0]  frame_size_reg;
    logic [UPB_W-1:0]  upb_reg;
    logic [TIME_W-1:0] frame_end_reg, frame_end_next;

    logic              kind_reg;
    logic [TIME_W-1:0] now_reg;
    desc_t             item_reg;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t res;

    qctl_t qctl [3];
    qsts_t qsts [3];
    desc_t head  [3];
    fit_t  fit;

    logic              accept, out_free, finish, frame_restart;
    logic [QIDX_W-1:0] q_enq;
    logic              enq_ok;

    // descriptor queues
    qfb_desc_queue #(.DEPTH(HIGH_DEPTH)) u_high_q
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (qctl[Q_HIGH]),
        .wr_desc   (item_reg),
        .head_desc (head[Q_HIGH]),
        .sts       (qsts[Q_HIGH])
    );

    qfb_desc_queue #(.DEPTH(MIDDLE_DEPTH)) u_mid_q
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (qctl[Q_MID]),
        .wr_desc   (item_reg),
        .head_desc (head[Q_MID]),
        .sts       (qsts[Q_MID])
    );

    qfb_desc_queue #(.DEPTH(LOW_DEPTH)) u_low_q
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (qctl[Q_LOW]),
        .wr_desc   (item_reg),
        .head_desc (head[Q_LOW]),
        .sts       (qsts[Q_LOW])
    );

    // frame budget for the middle and low heads
    qfb_budget_check u_budget
    (
        .clk         (clk),
        .frame_end   (frame_end_reg),
        .now         (now_reg),
        .us_per_byte (upb_reg),
        .mid_size    (head[Q_MID].size),
        .low_size    (head[Q_LOW].size),
        .fit         (fit)
    );

    // handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign finish        = (state_reg == ST_DONE) && out_free;
    assign s_axis_tready = (state_reg == ST_IDLE) || finish;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // scheduling decision
    always_comb
    begin
        res = '0;
        qctl[Q_HIGH] = '0;
        qctl[Q_MID]  = '0;
        qctl[Q_LOW]  = '0;
        frame_restart = 1'b0;

        if (item_reg.qos < QOS_MID_MIN)
        begin
            q_enq = Q_HIGH;
        end
        else if (item_reg.qos < QOS_LOW_VAL)
        begin
            q_enq = Q_MID;
        end
        else
        begin
            q_enq = Q_LOW;
        end
        enq_ok = (item_reg.size <= SIZE_W'(MAX_PAYLOAD)) && !qsts[q_enq].full;

        if (kind_reg == KIND_ENQ)
        begin
            res.queue_index = q_enq;
            res.accepted    = enq_ok;
            qctl[q_enq].push = finish && enq_ok;
        end
        else
        begin
            res.granted = 1'b1;
            if (!qsts[Q_HIGH].empty)
            begin
                res.queue_index = Q_HIGH;
            end
            else if (!qsts[Q_MID].empty && fit.mid)
            begin
                res.queue_index = Q_MID;
            end
            else if (!qsts[Q_LOW].empty && fit.low)
            begin
                res.queue_index = Q_LOW;
            end
            else
            begin
                res.granted = 1'b0;
            end

            if (res.granted)
            begin
                res.grant_tag          = head[res.queue_index].tag;
                res.grant_payload_size = head[res.queue_index].size;
                res.grant_qos          = head[res.queue_index].qos;
                qctl[res.queue_index].pop = finish;
                frame_restart = finish && (res.queue_index == Q_HIGH) &&
                                (head[Q_HIGH].qos == QOS_RESTART);
            end
        end
    end

    // frame window restart
    assign frame_end_next = frame_restart ?
                            now_reg + TIME_W'(frame_size_reg) : frame_end_reg;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = accept ? ST_EVAL : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            frame_size_reg <= FRAME_SIZE_RST;
            upb_reg        <= US_PER_BYTE_RST;
            frame_end_reg  <= TIME_W'(FRAME_SIZE_RST);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            frame_end_reg <= frame_end_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FRAME_SIZE:  frame_size_reg <= cfg_data;
                    CFG_US_PER_BYTE: upb_reg <= cfg_data[UPB_W-1:0];
                    default:         upb_reg <= upb_reg;
                endcase
            end
        end
    end

    // item capture and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= s_axis_tuser;
            now_reg       <= s_axis_tdata[TIME_W-1:0];
            item_reg.qos  <= s_axis_tdata[39:32];
            item_reg.size <= s_axis_tdata[48:40];
            item_reg.tag  <= s_axis_tdata[56:49];
        end
        if (finish)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, out_reg};

    // checks
    `QFB_ASSERT_IMP(a_no_accept_in_eval, state_reg == ST_EVAL, !s_axis_tready, "accept during evaluation")
    `QFB_ASSERT_NXT(a_accept_to_eval, accept, state_reg == ST_EVAL, "accepted item not evaluated")
    `QFB_ASSERT_IMP(a_one_queue_op, 1'b1, $onehot0({qctl[Q_HIGH], qctl[Q_MID], qctl[Q_LOW]}), "more than one queue operation")
    `QFB_ASSERT_NXT(a_frame_end_hold, !frame_restart, $stable(frame_end_reg), "frame end moved without restart")

endmodule

// File: hw/rtl/qfb_desc_queue.sv
module qfb_desc_queue
    import qfb_pkg::*;
#(
    parameter int DEPTH = HIGH_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  qctl_t ctl,
    input  desc_t wr_desc,
    output desc_t head_desc,
    output qsts_t sts
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    desc_t mem [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    desc_t         head_desc_reg;

    // pointer and fill count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next  = (head_reg == LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (ctl.push)
        begin
            tail_next  = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // descriptor store, write at tail
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= wr_desc;
        end
    end

    // head read each cycle, forward a write landing on the new head
    always_ff @(posedge clk)
    begin
        if (ctl.push && (tail_reg == head_next))
        begin
            head_desc_reg <= wr_desc;
        end
        else
        begin
            head_desc_reg <= mem[head_next];
        end
    end

    assign head_desc = head_desc_reg;
    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg == CW'(DEPTH));

endmodule

// File: hw/rtl/qfb_budget_check.sv
module qfb_budget_check
    import qfb_pkg::*;
(
    input  logic              clk,
    input  logic [TIME_W-1:0] frame_end,
    input  logic [TIME_W-1:0] now,
    input  logic [UPB_W-1:0]  us_per_byte,
    input  logic [SIZE_W-1:0] mid_size,
    input  logic [SIZE_W-1:0] low_size,
    output fit_t              fit
);

    logic [TIME_W-1:0] left_reg;
    logic [COST_W-1:0] cost_mid_reg;
    logic [COST_W-1:0] cost_low_reg;
    logic [COST_SUM_W-1:0] sum_mid, sum_low;

    // bytes on the wire for each head
    assign sum_mid = COST_SUM_W'(HEADER_BYTES) + COST_SUM_W'(mid_size);
    assign sum_low = COST_SUM_W'(HEADER_BYTES) + COST_SUM_W'(low_size);

    // time left and transmit cost, registered
    always_ff @(posedge clk)
    begin
        left_reg     <= frame_end - now;
        cost_mid_reg <= COST_W'(us_per_byte) * COST_W'(sum_mid);
        cost_low_reg <= COST_W'(us_per_byte) * COST_W'(sum_low);
    end

    // serve only with positive time left and cost strictly below it
    assign fit.mid = !left_reg[TIME_W-1] &&
                     ({{(TIME_W-COST_W){1'b0}}, cost_mid_reg} < left_reg);
    assign fit.low = !left_reg[TIME_W-1] &&
                     ({{(TIME_W-COST_W){1'b0}}, cost_low_reg} < left_reg);

endmodule
